// ----- hdl/ofc_pkg.sv -----
`default_nettype none
package ofc_pkg;

	// Fixed field widths
	localparam int LEVEL_W   = 4;
	localparam int WEIGHT_W  = 16;
	localparam int CORR_W    = 17;
	localparam int SUM_W     = 19;  // seven Q4.12 weights, summed without loss
	localparam int MAG_W     = 18;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int FRAC_W    = 17;
	localparam int IDX_W     = 11;
	localparam int TAB_AW    = 12;
	localparam int TAB_SIZE  = 2049;
	localparam int PROD_W    = CORR_W + FRAC_W;

	localparam logic [CORR_W-1:0] ONE_Q16 = CORR_W'(65536);

	// Register map (index = paddr / 4)
	localparam int REG_IDX_W     = 3;
	localparam int ADDR_W        = REG_IDX_W + 2;
	localparam int NUM_STEP_REGS = 7;
	localparam logic [REG_IDX_W-1:0] REG_EQUAL_CORR = REG_IDX_W'(7);

	// Queue between classifier and exp pipeline
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	typedef struct packed {
		logic                    is_exp;  // result comes from the exp pipeline
		logic                    err;
		logic [CORR_W-1:0]       corr;    // result when not is_exp
		logic signed [SUM_W-1:0] sum;
	} ofc_item_t;

	typedef struct packed {
		logic              is_exp;
		logic              err;
		logic [CORR_W-1:0] corr;
	} ofc_meta_t;

	typedef logic [TAB_SIZE-1:0][CORR_W-1:0] exp_tab_t;

	// round(65536*exp(-i/128)), built by repeated Q0.32 multiplication
	function automatic exp_tab_t build_exp_tab();
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] e32;
		logic [63:0] v;
		exp_tab_t    t;
		term = 64'd1 << 60;
		acc  = term;
		for (int n = 1; n <= 8; n++) begin
			term = (term >> 7) / 64'(n);
			if ((n % 2) == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		e32 = (acc + (64'd1 << 27)) >> 28;
		v   = 64'd1 << 32;
		for (int i = 0; i < TAB_SIZE; i++) begin
			t[i] = CORR_W'((v + 64'd32768) >> 16);
			v    = (v * e32 + (64'd1 << 31)) >> 32;
		end
		return t;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/ofc_front.sv -----
`default_nettype none
module ofc_front #(
	parameter int NUM_LEVELS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [ofc_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [31:0]                       pwdata,
	output logic      [31:0]                       prdata,
	input  wire logic [ofc_pkg::LEVEL_W-1:0]       level_a,
	input  wire logic [ofc_pkg::LEVEL_W-1:0]       level_b,
	input  wire logic                              on_diagonal,
	output ofc_pkg::ofc_item_t                     item
);

	localparam int NUM_STEPS = NUM_LEVELS - 1;

	logic signed [ofc_pkg::WEIGHT_W-1:0] weight_q [NUM_STEPS];
	logic [ofc_pkg::CORR_W-1:0]          equal_corr_q;

	logic [ofc_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          wr_en;
	logic [ofc_pkg::LEVEL_W-1:0]   lo;
	logic [ofc_pkg::LEVEL_W-1:0]   hi;
	logic                          a_ok;
	logic                          b_ok;
	logic signed [ofc_pkg::SUM_W-1:0] part [ofc_pkg::NUM_STEP_REGS];
	logic signed [ofc_pkg::SUM_W-1:0] sum;

	assign reg_idx = paddr[ofc_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_STEPS; k++)
				weight_q[k] <= '0;
			equal_corr_q <= ofc_pkg::ONE_Q16;
		end else if (wr_en) begin
			for (int k = 0; k < NUM_STEPS; k++)
				if (reg_idx == ofc_pkg::REG_IDX_W'(k))
					weight_q[k] <= pwdata[ofc_pkg::WEIGHT_W-1:0];
			if (reg_idx == ofc_pkg::REG_EQUAL_CORR)
				equal_corr_q <= pwdata[ofc_pkg::CORR_W-1:0];
		end
	end

	// Weights at index NUM_LEVELS-1 and above are not held and read back as zero
	always_comb begin
		prdata = '0;
		for (int k = 0; k < NUM_STEPS; k++)
			if (reg_idx == ofc_pkg::REG_IDX_W'(k))
				prdata = {16'd0, weight_q[k]};
		if (reg_idx == ofc_pkg::REG_EQUAL_CORR)
			prdata = {15'd0, equal_corr_q};
	end

	assign a_ok = (level_a != '0) && (level_a <= ofc_pkg::LEVEL_W'(NUM_LEVELS));
	assign b_ok = (level_b != '0) && (level_b <= ofc_pkg::LEVEL_W'(NUM_LEVELS));
	assign lo   = (level_a < level_b) ? level_a : level_b;
	assign hi   = (level_a < level_b) ? level_b : level_a;

	// Weight k spans levels k+1 and k+2
	always_comb begin
		for (int k = 0; k < ofc_pkg::NUM_STEP_REGS; k++)
			part[k] = '0;
		for (int k = 0; k < NUM_STEPS; k++)
			if ((ofc_pkg::LEVEL_W'(k + 1) >= lo) && (ofc_pkg::LEVEL_W'(k + 1) < hi))
				part[k] = ofc_pkg::SUM_W'(weight_q[k]);
	end

	// adder tree, three levels deep
	assign sum = ((part[0] + part[1]) + (part[2] + part[3])) + ((part[4] + part[5]) + part[6]);

	always_comb begin
		item.is_exp = 1'b0;
		item.err    = 1'b0;
		item.corr   = '0;
		item.sum    = sum;
		if (!a_ok || !b_ok) begin
			item.err = 1'b1;
		end else if (on_diagonal) begin
			item.corr = ofc_pkg::ONE_Q16;
		end else if (level_a == level_b) begin
			item.corr = (equal_corr_q > ofc_pkg::ONE_Q16) ? ofc_pkg::ONE_Q16 : equal_corr_q;
		end else begin
			item.is_exp = 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/ofc_queue.sv -----
`default_nettype none
module ofc_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire ofc_pkg::ofc_item_t push_item,
	input  wire logic               pop,
	output ofc_pkg::ofc_item_t      head,
	output logic                    full,
	output logic                    empty
);

	ofc_pkg::ofc_item_t entry_q [ofc_pkg::QUEUE_DEPTH];

	logic [ofc_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [ofc_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [ofc_pkg::QUEUE_AW:0]   count_q;

	assign full  = (count_q == (ofc_pkg::QUEUE_AW+1)'(ofc_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/ofc_back.sv -----
`default_nettype none
module ofc_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ofc_pkg::ofc_item_t           head,
	input  wire logic                         empty,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [ofc_pkg::CORR_W-1:0]        corr_value,
	output logic                              level_error
);

	localparam ofc_pkg::exp_tab_t EXP_TAB = ofc_pkg::build_exp_tab();

	logic en;

	logic                             v_s1, v_s2, v_s3, v_s4;
	ofc_pkg::ofc_meta_t               meta_s1, meta_s2, meta_s3, meta_s4;
	logic [ofc_pkg::MAG_W-1:0]        mag_s1;
	logic [ofc_pkg::SQ_W-1:0]         sq_s2;
	logic [ofc_pkg::CORR_W-1:0]       ta_s3, tb_s3, ta_s4;
	logic [ofc_pkg::FRAC_W-1:0]       frac_s3;
	logic                             zero_s3, zero_s4;
	logic [ofc_pkg::PROD_W-1:0]       prod_s4;

	logic                             out_valid_q;
	logic [ofc_pkg::CORR_W-1:0]       corr_q;
	logic                             err_q;

	logic [ofc_pkg::MAG_W-1:0]        mag;
	logic [ofc_pkg::IDX_W-1:0]        idx;
	logic [ofc_pkg::TAB_AW-1:0]       idx_next;
	logic [ofc_pkg::PROD_W-1:0]       rnd;
	logic [ofc_pkg::CORR_W-1:0]       exp_val;

	// Whole pipeline moves together; it halts only when the result register is held
	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !empty;

	assign mag = head.sum[ofc_pkg::SUM_W-1] ? ofc_pkg::MAG_W'(-head.sum)
	                                        : ofc_pkg::MAG_W'(head.sum);

	assign idx      = sq_s2[ofc_pkg::IDX_W+ofc_pkg::FRAC_W-1:ofc_pkg::FRAC_W];
	assign idx_next = ofc_pkg::TAB_AW'(idx) + 1'b1;

	assign rnd     = (prod_s4 + ofc_pkg::PROD_W'(65536)) >> ofc_pkg::FRAC_W;
	assign exp_val = zero_s4 ? '0 : ta_s4 - rnd[ofc_pkg::CORR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= !empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= '{is_exp: head.is_exp, err: head.err, corr: head.corr};
			mag_s1  <= mag;

			meta_s2 <= meta_s1;
			sq_s2   <= ofc_pkg::SQ_W'(mag_s1) * ofc_pkg::SQ_W'(mag_s1);

			// sum^2 of 16 or more underflows to zero
			meta_s3 <= meta_s2;
			zero_s3 <= |sq_s2[ofc_pkg::SQ_W-1:ofc_pkg::IDX_W+ofc_pkg::FRAC_W];
			frac_s3 <= sq_s2[ofc_pkg::FRAC_W-1:0];
			ta_s3   <= EXP_TAB[ofc_pkg::TAB_AW'(idx)];
			tb_s3   <= EXP_TAB[idx_next];

			meta_s4 <= meta_s3;
			zero_s4 <= zero_s3;
			ta_s4   <= ta_s3;
			prod_s4 <= ofc_pkg::PROD_W'(ta_s3 - tb_s3) * ofc_pkg::PROD_W'(frac_s3);

			corr_q  <= meta_s4.is_exp ? exp_val : meta_s4.corr;
			err_q   <= meta_s4.err;
		end
	end

	assign out_valid   = out_valid_q;
	assign corr_value  = corr_q;
	assign level_error = err_q;

endmodule
`default_nettype wire

// ----- hdl/ordered_factor_correlation_unit.sv -----
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   level_a, level_b, on_diagonal
// out      output     out_valid / out_stall corr_value, level_error
// cfg      input      APB write, pready=1   step_weight_1..7, equal_level_corr
//
// One level pair per cycle while in_stall is low; a result passes the queue entry,
// the four-stage exp pipeline (magnitude, square, table read, slope product) and
// the result register, where the interpolation is applied.
// Reset clears the queue, the pipeline valids and the registers to their reset values.
// out_stall on a held result freezes the whole exp pipeline; the four-entry queue keeps taking
// items until full, and in_stall is simply the queue being full.
`default_nettype none
module ordered_factor_correlation_unit #(
	parameter int NUM_LEVELS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ofc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [ofc_pkg::LEVEL_W-1:0]  level_a,
	input  wire logic [ofc_pkg::LEVEL_W-1:0]  level_b,
	input  wire logic                         on_diagonal,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [ofc_pkg::CORR_W-1:0]        corr_value,
	output logic                              level_error
);

	ofc_pkg::ofc_item_t item;
	ofc_pkg::ofc_item_t head;
	logic               full;
	logic               empty;
	logic               pop;
	logic               push;

	assign pready   = 1'b1;
	assign in_stall = full;
	assign push     = in_valid && !full;

	ofc_front #(
		.NUM_LEVELS (NUM_LEVELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.level_a     (level_a),
		.level_b     (level_b),
		.on_diagonal (on_diagonal),
		.item        (item)
	);

	ofc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (item),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	ofc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.corr_value  (corr_value),
		.level_error (level_error)
	);

endmodule
`default_nettype wire

// ----- hdl/ofc_checker.sv -----
`default_nettype none
module ofc_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [ofc_pkg::CORR_W-1:0]   corr_value,
	input wire logic                         level_error
);

	// A held result stays put until transferred
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(corr_value) && $stable(level_error))
		else $error("result changed while stalled");

	ap_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && level_error |-> corr_value == '0)
		else $error("level error with non-zero correlation");

	ap_corr_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> corr_value <= ofc_pkg::ONE_Q16)
		else $error("correlation above one");

	// The queue only fills up behind a result that is being held
	ap_full_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

endmodule

bind ordered_factor_correlation_unit ofc_checker u_ofc_checker (.*);
`default_nettype wire

// ----- verif/ordered_factor_correlation_unit_tb.sv -----
`default_nettype none
module ordered_factor_correlation_unit_tb;

	localparam int NUM_LEVELS = 8;
	localparam int GAUSS_ENTRIES = 2049;
	localparam int SETTLE_CYCLES = 10;

	typedef struct {
		logic [ofc_pkg::CORR_W-1:0] corr;
		logic                       err;
	} corr_result_t;

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [ofc_pkg::ADDR_W-1:0]   paddr = '0;
	logic [31:0]                  pwdata = '0;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [ofc_pkg::LEVEL_W-1:0]  level_a = '0;
	logic [ofc_pkg::LEVEL_W-1:0]  level_b = '0;
	logic                         on_diagonal = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [ofc_pkg::CORR_W-1:0]   corr_value;
	logic                         level_error;

	// local copy of the register file and the exp table
	logic signed [ofc_pkg::WEIGHT_W-1:0] step_w [ofc_pkg::NUM_STEP_REGS];
	logic [ofc_pkg::CORR_W-1:0]          equal_corr;
	logic [ofc_pkg::CORR_W-1:0]          gauss_tab [GAUSS_ENTRIES];

	corr_result_t corr_expect_q [$];
	int           fail_count = 0;
	bit           quiet = 1'b0;
	int           stall_left = 0;

	ordered_factor_correlation_unit #(.NUM_LEVELS(NUM_LEVELS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.level_a(level_a), .level_b(level_b), .on_diagonal(on_diagonal),
		.out_valid(out_valid), .out_stall(out_stall),
		.corr_value(corr_value), .level_error(level_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// exp(-i/128) in Q.16, stepped up from exp(-1/128) in Q0.32
	task automatic fill_gauss_tab();
		longint unsigned term;
		longint unsigned series;
		longint unsigned ratio;
		longint unsigned acc;
		term = 64'd1 << 60;
		series = term;
		for (int n = 1; n <= 8; n++) begin
			term = (term >> 7) / 64'(n);
			if (n % 2 == 1)
				series -= term;
			else
				series += term;
		end
		ratio = (series + (64'd1 << 27)) >> 28;
		acc = 64'd1 << 32;
		for (int i = 0; i < GAUSS_ENTRIES; i++) begin
			gauss_tab[i] = ofc_pkg::CORR_W'((acc + 64'd32768) >> 16);
			acc = (acc * ratio + (64'd1 << 31)) >> 32;
		end
	endtask

	function automatic logic [ofc_pkg::CORR_W-1:0] gauss_interp(longint unsigned sq);
		int unsigned     idx;
		longint unsigned frac;
		longint unsigned slope;
		if (sq >= (64'd1 << 28))
			return '0;
		idx = int'(sq >> 17);
		frac = sq & 64'h1FFFF;
		slope = 64'(gauss_tab[idx]) - 64'(gauss_tab[idx + 1]);
		return gauss_tab[idx] - ofc_pkg::CORR_W'((slope * frac + 64'd65536) >> 17);
	endfunction

	function automatic corr_result_t predict_corr(logic [ofc_pkg::LEVEL_W-1:0] a,
			logic [ofc_pkg::LEVEL_W-1:0] b, logic diag);
		corr_result_t    r;
		int              lo;
		int              hi;
		int              total;
		longint unsigned mag;
		r.corr = '0;
		r.err = 1'b0;
		if (a == 0 || a > NUM_LEVELS || b == 0 || b > NUM_LEVELS) begin
			r.err = 1'b1;
		end else if (diag) begin
			r.corr = ofc_pkg::ONE_Q16;
		end else if (a == b) begin
			r.corr = (equal_corr > ofc_pkg::ONE_Q16) ? ofc_pkg::ONE_Q16 : equal_corr;
		end else begin
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			total = 0;
			for (int k = lo; k < hi; k++)
				total += int'(step_w[k - 1]);
			mag = (total < 0) ? longint'(-total) : longint'(total);
			r.corr = gauss_interp(mag * mag);
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// receiver back-pressure: mostly short stalls, now and then a long one
	always @(posedge clk) begin
		if (quiet || stall_left == 0) begin
			out_stall <= 1'b0;
			if (!quiet && $urandom_range(0, 99) < 20)
				stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
					: $urandom_range(8, 40);
		end else begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin
		corr_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (corr_expect_q.size() == 0) begin
				$error("result transfer with nothing expected: corr_value %0d level_error %0b",
					corr_value, level_error);
				fail_count++;
			end else begin
				want = corr_expect_q.pop_front();
				if (corr_value !== want.corr) begin
					$error("corr_value: expected %0d, got %0d", want.corr, corr_value);
					fail_count++;
				end
				if (level_error !== want.err) begin
					$error("level_error: expected %0b, got %0b", want.err, level_error);
					fail_count++;
				end
			end
		end
	end

	// valid stays high after a transfer; the next call or wait_idle decides
	task automatic send_pair(input logic [ofc_pkg::LEVEL_W-1:0] a,
			input logic [ofc_pkg::LEVEL_W-1:0] b, input logic diag);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		level_a <= a;
		level_b <= b;
		on_diagonal <= diag;
		do @(posedge clk); while (in_stall);
		corr_expect_q.push_back(predict_corr(a, b, diag));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (corr_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input int index, input logic [31:0] data);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ofc_pkg::ADDR_W'(index * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (index < ofc_pkg::NUM_STEP_REGS)
			step_w[index] = data[ofc_pkg::WEIGHT_W-1:0];
		else if (index == int'(ofc_pkg::REG_EQUAL_CORR))
			equal_corr = data[ofc_pkg::CORR_W-1:0];
	endtask

	task automatic send_random_pair();
		logic [ofc_pkg::LEVEL_W-1:0] a;
		logic [ofc_pkg::LEVEL_W-1:0] b;
		a = ($urandom_range(0, 99) < 88) ? ofc_pkg::LEVEL_W'($urandom_range(1, NUM_LEVELS))
			: ofc_pkg::LEVEL_W'($urandom_range(0, 15));
		b = ($urandom_range(0, 99) < 88) ? ofc_pkg::LEVEL_W'($urandom_range(1, NUM_LEVELS))
			: ofc_pkg::LEVEL_W'($urandom_range(0, 15));
		send_pair(a, b, $urandom_range(0, 99) < 15);
	endtask

	task automatic test_reset_defaults();
		// all weights zero: any distinct valid pair gives exp(0)
		send_pair(4'd1, 4'd2, 1'b0);
		send_pair(4'd8, 4'd1, 1'b0);
		send_pair(4'd3, 4'd3, 1'b0);
		send_pair(4'd5, 4'd5, 1'b1);
		send_pair(4'd0, 4'd4, 1'b0);
		send_pair(4'd4, 4'd9, 1'b1);
		send_pair(4'd15, 4'd15, 1'b1);
	endtask

	task automatic test_directed_extremes();
		write_register(0, 32'h0000_7FFF);
		write_register(1, 32'hFFFF_8000);
		write_register(2, 32'h0000_1000);
		write_register(3, 32'h0000_F000);
		write_register(4, 32'h0000_0000);
		write_register(5, 32'h0000_0001);
		write_register(6, 32'h0000_3FFF);
		write_register(int'(ofc_pkg::REG_EQUAL_CORR), 32'h0000_0000);
		send_pair(4'd1, 4'd2, 1'b0);
		send_pair(4'd2, 4'd3, 1'b0);
		send_pair(4'd1, 4'd3, 1'b0);
		send_pair(4'd3, 4'd4, 1'b0);
		send_pair(4'd4, 4'd3, 1'b0);
		send_pair(4'd3, 4'd5, 1'b0);
		send_pair(4'd6, 4'd7, 1'b0);
		send_pair(4'd7, 4'd8, 1'b0);
		// sum exactly 4.0: square hits the cut-off
		send_pair(4'd6, 4'd8, 1'b0);
		send_pair(4'd4, 4'd4, 1'b0);
		send_pair(4'd2, 4'd2, 1'b1);
		send_pair(4'd8, 4'd0, 1'b1);
		// out-of-range equal-level value saturates to 1.0
		write_register(int'(ofc_pkg::REG_EQUAL_CORR), 32'hFFFF_FFFF);
		send_pair(4'd7, 4'd7, 1'b0);
		send_pair(4'd8, 4'd8, 1'b0);
		write_register(int'(ofc_pkg::REG_EQUAL_CORR), 32'h0001_0000);
		send_pair(4'd6, 4'd6, 1'b0);
		send_pair(4'd9, 4'd9, 1'b0);
	endtask

	task automatic load_random_config(input bit wide);
		logic [31:0] data;
		for (int k = 0; k < ofc_pkg::NUM_STEP_REGS; k++) begin
			data = $urandom();
			if (!wide || $urandom_range(0, 99) < 70)
				data[15:0] = 16'($urandom_range(0, 8191) - 4096);
			write_register(k, data);
		end
		data = $urandom();
		if ($urandom_range(0, 99) < 70)
			data[16:0] = 17'($urandom_range(0, 65536));
		write_register(int'(ofc_pkg::REG_EQUAL_CORR), data);
	endtask

	task automatic test_random_traffic(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			load_random_config(p % 2 == 1);
			repeat (per_phase) send_random_pair();
		end
	endtask

	task automatic test_back_to_back();
		quiet = 1'b1;
		repeat (150) send_random_pair();
		quiet = 1'b0;
	endtask

	task automatic test_drain_midstream();
		repeat (40) send_random_pair();
		wait_idle();
		repeat (40) send_random_pair();
	endtask

	initial begin
		fill_gauss_tab();
		for (int k = 0; k < ofc_pkg::NUM_STEP_REGS; k++)
			step_w[k] = '0;
		equal_corr = ofc_pkg::ONE_Q16;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_extremes();
		test_random_traffic(5, 200);
		test_back_to_back();
		test_drain_midstream();
		test_random_traffic(1, 50);

		wait_idle();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
